// ----- rtl/osm_pkg.sv -----
`default_nettype none
package osm_pkg;
  localparam int TotalBits = 24;

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_DELETE = 3'd1;
  localparam logic [2:0] CMD_RANK   = 3'd2;
  localparam logic [2:0] CMD_KTH    = 3'd3;
  localparam logic [2:0] CMD_PRED   = 3'd4;
  localparam logic [2:0] CMD_SUCC   = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_RANGE    = 2'd3;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] value;
    logic [23:0]        position;
  } osm_req_t;

  typedef struct packed {
    logic signed [31:0] answer;
    logic [1:0]         status;
  } osm_rsp_t;
endpackage
`default_nettype wire

// ----- rtl/order_statistic_multiset_top.sv -----
// channel | signals                 | payload
// req     | req_valid / req_ready   | osm_req_t {cmd, value, position}
// rsp     | rsp_valid / rsp_ready   | osm_rsp_t {answer, status}
// One request at a time. A scan reads entries 0..used-1, one per cycle, through
// the registered memory read port. Insert of a new value / delete of a last copy
// then shifts the tail one entry at a time, each entry a read then a write.
// Reset clears the state, entry count, copy total and response flag; memories are not cleared.
// A finished response sits in an output register; the next request is taken
// while it waits, but its own response holds until the register is free.
`default_nettype none
module order_statistic_multiset_top
  import osm_pkg::*;
#(
  parameter int CAPACITY   = 256,
  parameter int COUNT_BITS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_ready,
  input  wire osm_req_t req,
  output logic          rsp_valid,
  input  wire logic     rsp_ready,
  output osm_rsp_t      rsp
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int UW = $clog2(CAPACITY + 1);
  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_SHUP = 3'd3;
  localparam logic [2:0] S_SHDN = 3'd4;
  localparam logic [2:0] S_PUT  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic signed [31:0] val_mem [CAPACITY];
  logic [COUNT_BITS-1:0] cnt_mem [CAPACITY];
  logic signed [31:0] rd_val;
  logic [COUNT_BITS-1:0] rd_cnt;

  logic [2:0] state;
  osm_req_t cur;
  logic [UW-1:0] used;
  logic [TotalBits-1:0] total;
  logic [UW-1:0] idx;       // next address issued
  logic rd_pend;             // data for idx-1 arrives this cycle
  logic [UW-1:0] slot;       // lower slot
  logic slot_found;
  logic present;
  logic [COUNT_BITS-1:0] slot_cnt;
  logic [TotalBits-1:0] acc;
  logic [TotalBits-1:0] kacc; // copies passed so far for kth
  logic signed [31:0] pred_v;
  logic signed [31:0] succ_v;
  logic have_succ;
  logic signed [31:0] kth_v;
  logic kth_found;
  logic [UW-1:0] sh;         // shift pointer

  logic we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic signed [31:0] wval;
  logic [COUNT_BITS-1:0] wcnt;

  logic rsp_hold;
  logic done_fire;
  logic signed [31:0] done_ans;
  logic [1:0] done_st;
  logic [2:0] done_state;

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = rsp_hold;
  assign done_fire = (state == S_DONE) && (!rsp_hold || rsp_ready);

  always_ff @(posedge clk) begin
    if (we) begin
      val_mem[waddr] <= wval;
      cnt_mem[waddr] <= wcnt;
    end
    rd_val <= val_mem[raddr];
    rd_cnt <= cnt_mem[raddr];
  end

  // combinational memory control
  always_comb begin
    we = 1'b0;
    waddr = sh[AW-1:0];
    wval = rd_val;
    wcnt = rd_cnt;
    raddr = idx[AW-1:0];
    case (state)
      S_DEC: begin
        we = 1'b1;
        waddr = slot[AW-1:0];
        wval = cur.value;
        wcnt = (cur.cmd == CMD_INSERT) ? slot_cnt + 1'b1 : slot_cnt - 1'b1;
      end
      S_SHUP: begin
        raddr = AW'(sh - 1'b1);
        we = rd_pend;
        waddr = sh[AW-1:0];
      end
      S_SHDN: begin
        raddr = AW'(sh + 1'b1);
        we = rd_pend;
        waddr = sh[AW-1:0];
      end
      S_PUT: begin
        we = 1'b1;
        waddr = slot[AW-1:0];
        wval = cur.value;
        wcnt = COUNT_BITS'(1);
      end
      default: ;
    endcase
  end

  // response and follow-up state once the scan is complete
  always_comb begin
    done_ans = '0;
    done_st = ST_OK;
    done_state = S_IDLE;
    case (cur.cmd)
      CMD_INSERT: begin
        if (total == {TotalBits{1'b1}}) done_st = ST_FULL;
        else if (present) begin
          if (slot_cnt == CountMax) done_st = ST_FULL;
          else done_state = S_DEC;
        end else if (used == UW'(CAPACITY)) done_st = ST_FULL;
        else done_state = (used == slot) ? S_PUT : S_SHUP;
      end
      CMD_DELETE: begin
        if (!present) done_st = ST_NOTFOUND;
        else if (slot_cnt > COUNT_BITS'(1)) done_state = S_DEC;
        else if (slot + 1'b1 < used) done_state = S_SHDN;
      end
      CMD_RANK: done_ans = 32'(acc) + 32'sd1;
      CMD_KTH: begin
        if (cur.position == '0 || cur.position > total) done_st = ST_RANGE;
        else done_ans = kth_v;
      end
      CMD_PRED: begin
        if (slot == '0) done_st = ST_RANGE;
        else done_ans = pred_v;
      end
      CMD_SUCC: begin
        if (!have_succ) done_st = ST_RANGE;
        else done_ans = succ_v;
      end
      default: ;
    endcase
  end

  logic [TotalBits-1:0] left_now;
  assign left_now = cur.position - kacc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used <= '0;
      total <= '0;
      rsp_hold <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      rsp_hold <= done_fire || (rsp_hold && !rsp_ready);
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur <= req;
            idx <= '0;
            rd_pend <= 1'b0;
            slot_found <= 1'b0;
            slot <= used;
            present <= 1'b0;
            acc <= '0;
            kacc <= '0;
            have_succ <= 1'b0;
            kth_found <= 1'b0;
            pred_v <= '0;
            succ_v <= '0;
            kth_v <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_pend) begin
            // entry idx-1 available in rd_val/rd_cnt
            if (!slot_found) begin
              if (rd_val < cur.value) begin
                pred_v <= rd_val;
                acc <= acc + TotalBits'(rd_cnt);
              end else begin
                slot_found <= 1'b1;
                slot <= idx - 1'b1;
                present <= (rd_val == cur.value);
                slot_cnt <= rd_cnt;
              end
            end
            if (!have_succ && rd_val > cur.value) begin
              have_succ <= 1'b1;
              succ_v <= rd_val;
            end
            if (cur.cmd == CMD_KTH && !kth_found) begin
              if (left_now <= TotalBits'(rd_cnt)) begin
                kth_found <= 1'b1;
                kth_v <= rd_val;
              end else kacc <= kacc + TotalBits'(rd_cnt);
            end
          end
          if (idx < used) begin
            idx <= idx + 1'b1;
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            if (!rd_pend) state <= S_DONE;
          end
        end
        S_DONE: begin
          if (done_fire) begin
            rsp.answer <= done_ans;
            rsp.status <= done_st;
            state <= done_state;
            if (cur.cmd == CMD_INSERT && done_st == ST_OK) begin
              total <= total + 1'b1;
              if (!present) begin
                used <= used + 1'b1;
                sh <= used;
              end
            end
            if (cur.cmd == CMD_DELETE && done_st == ST_OK) begin
              total <= total - 1'b1;
              if (!(slot_cnt > COUNT_BITS'(1))) begin
                used <= used - 1'b1;
                sh <= slot;
              end
            end
          end
        end
        S_DEC: state <= S_IDLE;
        S_SHUP: begin
          // read sh-1, then write it to sh
          if (rd_pend) begin
            rd_pend <= 1'b0;
            sh <= sh - 1'b1;
            if (sh - 1'b1 == slot) state <= S_PUT;
          end else rd_pend <= 1'b1;
        end
        S_SHDN: begin
          if (rd_pend) begin
            rd_pend <= 1'b0;
            sh <= sh + 1'b1;
            if (sh + 1'b1 >= used) state <= S_IDLE;
          end else rd_pend <= 1'b1;
        end
        S_PUT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) used <= UW'(CAPACITY))
    else $error("entry count above capacity");
  assert property (@(posedge clk) disable iff (rst) (rsp_valid && !rsp_ready) |=> rsp_valid)
    else $error("response dropped");
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> $stable(rsp))
    else $error("response changed while waiting");
  assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !req_ready)
    else $error("request taken while busy");
endmodule
`default_nettype wire

// ----- tb/order_statistic_multiset_top_tb.sv -----
`timescale 1ns / 1ps
module order_statistic_multiset_top_tb;
  import osm_pkg::*;

  localparam int Capacity = 256;
  localparam int CountMax = 65535;
  localparam int TotalMax = 24'hFFFFFF;
  localparam int NumRandom = 1350;
  localparam longint CycleLimit = 10000000;

  // Shadow multiset plus a FIFO of expected responses.
  class multiset_scoreboard;
    logic signed [31:0] keys[$];
    int unsigned        copies[$];
    int unsigned        total;
    osm_rsp_t           pending[$];
    int                 errors;
    int                 checked;

    function void clear();
      keys.delete();
      copies.delete();
      total = 0;
      pending.delete();
      errors = 0;
      checked = 0;
    endfunction

    function int unsigned slot_of(logic signed [31:0] v);
      int unsigned i;
      i = 0;
      while (i < keys.size() && keys[i] < v) i++;
      return i;
    endfunction

    function void note_request(osm_req_t r);
      osm_rsp_t    o;
      int unsigned s;
      int unsigned acc;
      int unsigned left;
      bit          hit;
      o.answer = '0;
      o.status = ST_OK;
      s = slot_of(r.value);
      hit = (s < keys.size()) && (keys[s] == r.value);
      case (r.cmd)
        CMD_INSERT: begin
          if (total >= TotalMax) o.status = ST_FULL;
          else if (hit) begin
            if (copies[s] >= CountMax) o.status = ST_FULL;
            else begin
              copies[s]++;
              total++;
            end
          end else if (keys.size() >= Capacity) o.status = ST_FULL;
          else begin
            keys.insert(s, r.value);
            copies.insert(s, 1);
            total++;
          end
        end
        CMD_DELETE: begin
          if (!hit) o.status = ST_NOTFOUND;
          else begin
            total--;
            if (copies[s] > 1) copies[s]--;
            else begin
              keys.delete(s);
              copies.delete(s);
            end
          end
        end
        CMD_RANK: begin
          acc = 1;
          for (int i = 0; i < s; i++) acc += copies[i];
          o.answer = acc;
        end
        CMD_KTH: begin
          if (r.position == 0 || r.position > total) o.status = ST_RANGE;
          else begin
            left = r.position;
            for (int i = 0; i < keys.size(); i++) begin
              if (left <= copies[i]) begin
                o.answer = keys[i];
                break;
              end
              left -= copies[i];
            end
          end
        end
        CMD_PRED: begin
          if (s == 0) o.status = ST_RANGE;
          else o.answer = keys[s-1];
        end
        CMD_SUCC: begin
          if (hit) s++;
          if (s >= keys.size()) o.status = ST_RANGE;
          else o.answer = keys[s];
        end
        default: ;
      endcase
      pending.push_back(o);
    endfunction

    function void check_response(osm_rsp_t got);
      osm_rsp_t want;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected response answer=%0d status=%0d", $time, got.answer,
                 got.status);
        return;
      end
      want = pending.pop_front();
      if (got.answer !== want.answer) begin
        errors++;
        $display("%0t: answer mismatch expected %0d actual %0d", $time, want.answer,
                 got.answer);
      end
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status mismatch expected %0d actual %0d", $time, want.status,
                 got.status);
      end
    endfunction
  endclass

  logic     clk;
  logic     rst;
  logic     req_valid;
  logic     req_ready;
  osm_req_t req;
  logic     rsp_valid;
  logic     rsp_ready;
  osm_rsp_t rsp;

  multiset_scoreboard sb;
  longint cycles = 0;
  bit     stim_done;
  int     cmd_hist[8];

  order_statistic_multiset_top DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("order_statistic_multiset_top verification failed");
      $finish;
    end
  end

  // Response side: sample at rising edge, random stalls.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_response(rsp);
  end

  initial begin
    int gap;
    rsp_ready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        rsp_ready <= 0;
        repeat (gap) @(negedge clk);
      end
      rsp_ready <= 1;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Leaves valid high after the accepting edge; the next call drops it or
  // replaces the payload at that falling edge.
  task automatic send_request(input logic [2:0] c, input logic signed [31:0] v,
                              input logic [23:0] p, input int gap);
    osm_req_t r;
    r.cmd = c;
    r.value = v;
    r.position = p;
    if (gap > 0) begin
      req_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    req <= r;
    req_valid <= 1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.note_request(r);
    cmd_hist[c]++;
    @(negedge clk);
  endtask

  function automatic int draw_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
  endfunction

  // Values from a small pool so hits are common; sometimes fully random.
  function automatic logic signed [31:0] draw_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: return $signed($urandom_range(0, 60)) - 30;
    endcase
  endfunction

  initial begin
    logic [2:0]  c;
    logic [23:0] p;
    sb = new();
    sb.clear();
    stim_done = 0;
    rst = 1;
    req_valid = 0;
    req = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: empty-set corners, extremes, duplicates, delete of absent
    send_request(CMD_DELETE, 5, 0, 0);
    send_request(CMD_KTH, 0, 0, 0);
    send_request(CMD_PRED, 0, 0, 0);
    send_request(CMD_SUCC, 0, 0, 0);
    send_request(CMD_RANK, 32'sh7FFFFFFF, 0, 0);
    send_request(CMD_INSERT, 32'sh80000000, 0, 0);
    send_request(CMD_INSERT, 32'sh7FFFFFFF, 0, 1);
    send_request(CMD_INSERT, 0, 0, 0);
    send_request(CMD_INSERT, 0, 0, 2);
    send_request(CMD_INSERT, -1, 0, 0);
    send_request(CMD_RANK, 0, 0, 0);
    send_request(CMD_RANK, 32'sh7FFFFFFF, 0, 0);
    send_request(CMD_KTH, 0, 24'd4, 0);
    send_request(CMD_KTH, 0, 24'hFFFFFF, 0);
    send_request(CMD_KTH, 0, 24'd1, 0);
    send_request(CMD_PRED, 32'sh80000000, 0, 0);
    send_request(CMD_SUCC, 32'sh7FFFFFFF, 0, 0);
    send_request(CMD_PRED, 32'sh7FFFFFFF, 0, 0);
    send_request(CMD_SUCC, 32'sh80000000, 0, 0);
    send_request(CMD_DELETE, 0, 0, 0);
    send_request(CMD_DELETE, 3, 0, 0);
    send_request(3'd6, 32'shFFFFFFFF, 24'hFFFFFF, 0);
    send_request(3'd7, 0, 0, 0);

    // fill past capacity so the full status shows up
    for (int i = 0; i < Capacity + 4; i++) begin
      send_request(CMD_INSERT, $signed(i * 7919) - 1000000, 0, (i % 8 == 0) ? draw_gap() : 0);
    end
    send_request(CMD_KTH, 0, 24'(Capacity), 0);
    for (int i = 0; i < Capacity - 40; i++)
      send_request(CMD_DELETE, $signed(i * 7919) - 1000000, 0, 0);

    for (int n = 0; n < NumRandom; n++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: c = CMD_INSERT;
        6, 7, 8:          c = CMD_DELETE;
        9, 10:            c = CMD_RANK;
        11, 12, 13:       c = CMD_KTH;
        14, 15:           c = CMD_PRED;
        16, 17:           c = CMD_SUCC;
        18:               c = 3'($urandom_range(0, 7));
        default:          c = 3'($urandom_range(6, 7));
      endcase
      p = $urandom_range(0, 9) == 0 ? 24'($urandom()) : 24'($urandom_range(0, sb.total + 2));
      send_request(c, draw_value(), p, draw_gap());
    end
    req_valid <= 0;

    // wait for outstanding responses, then drain margin
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (2 * Capacity + 50) @(posedge clk);
    $display("Covered %0d responses: ins %0d del %0d rank %0d kth %0d pred %0d succ %0d",
             sb.checked, cmd_hist[CMD_INSERT], cmd_hist[CMD_DELETE], cmd_hist[CMD_RANK],
             cmd_hist[CMD_KTH], cmd_hist[CMD_PRED], cmd_hist[CMD_SUCC]);
    $display("Includes a capacity fill, extreme values and unused commands (%0d).",
             cmd_hist[6] + cmd_hist[7]);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("order_statistic_multiset_top verification clean");
    else
      $display("order_statistic_multiset_top verification failed");
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/osm_pkg.sv
rtl/order_statistic_multiset_top.sv
tb/order_statistic_multiset_top_tb.sv
